// ===== src/ecgr_pkg.sv =====
// Shared types, constants and the control program of the ECG R-peak and heart-rate block.
package ecgr_pkg;

  localparam int AVG_DEPTH_DEFAULT   = 4;
  localparam int FRAC_BITS_DEFAULT   = 10;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  localparam int SAMPLE_W    = 12;
  localparam int ALPHA_W     = 11;
  localparam int THRESH_W    = 12;
  localparam int REFR_W      = 16;
  localparam int NUMER_W     = 16;
  localparam int RATE_W      = 8;
  localparam int DIV_W       = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ALPHA_SHIFT = 10;
  localparam int CENTER_INT  = 2048;
  localparam int STEP_W      = 4;

  localparam logic [ALPHA_W-1:0]  ALPHA_ONE       = 11'd1024;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET     = 11'd410;
  localparam logic [THRESH_W-1:0] THRESH_RESET    = 12'd2300;
  localparam logic [REFR_W-1:0]   REFR_RESET      = 16'd40;
  localparam logic [NUMER_W-1:0]  NUMER_RESET     = 16'd12000;
  localparam logic [RATE_W-1:0]   RATE_MIN_RESET  = 8'd30;
  localparam logic [RATE_W-1:0]   RATE_MAX_RESET  = 8'd220;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ALPHA    = 3'd0,
    CFG_THRESH   = 3'd1,
    CFG_REFR     = 3'd2,
    CFG_NUMER    = 3'd3,
    CFG_RATE_MIN = 3'd4,
    CFG_RATE_MAX = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]  alpha;
    logic [THRESH_W-1:0] thresh;
    logic [REFR_W-1:0]   refr;
    logic [NUMER_W-1:0]  numer;
    logic [RATE_W-1:0]   rate_min;
    logic [RATE_W-1:0]   rate_max;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_MUL_OLD,
    OP_MUL_NEW,
    OP_FILTER,
    OP_TEST,
    OP_MARK,
    OP_DIV_RATE,
    OP_NOP,
    OP_ENTER,
    OP_DIV_AVG,
    OP_HOLD,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_NOT_PEAK,
    C_NO_RATE,
    C_DIV_BUSY,
    C_OUT_RANGE,
    C_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            stay;
    cond_t            jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic not_peak;
    logic no_rate;
    logic div_busy;
    logic out_range;
    logic out_blocked;
  } status_t;

  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_OLD  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_NEW  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_FILTER   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TEST     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MARK     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DIV_RATE = 4'd6;
  localparam logic [STEP_W-1:0] STEP_WAIT_R   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RANGE    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ENTER    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DIV_AVG  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_WAIT_A   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_HOLD     = 4'd12;
  localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd13;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      STEP_IDLE:     w = '{OP_IDLE,     C_NO_INPUT,    C_NEVER,     STEP_IDLE};
      STEP_MUL_OLD:  w = '{OP_MUL_OLD,  C_NEVER,       C_NEVER,     STEP_IDLE};
      STEP_MUL_NEW:  w = '{OP_MUL_NEW,  C_NEVER,       C_NEVER,     STEP_IDLE};
      STEP_FILTER:   w = '{OP_FILTER,   C_NEVER,       C_NEVER,     STEP_IDLE};
      STEP_TEST:     w = '{OP_TEST,     C_NEVER,       C_NOT_PEAK,  STEP_FINISH};
      STEP_MARK:     w = '{OP_MARK,     C_NEVER,       C_NO_RATE,   STEP_FINISH};
      STEP_DIV_RATE: w = '{OP_DIV_RATE, C_NEVER,       C_NEVER,     STEP_IDLE};
      STEP_WAIT_R:   w = '{OP_NOP,      C_DIV_BUSY,    C_NEVER,     STEP_IDLE};
      STEP_RANGE:    w = '{OP_NOP,      C_NEVER,       C_OUT_RANGE, STEP_FINISH};
      STEP_ENTER:    w = '{OP_ENTER,    C_NEVER,       C_NEVER,     STEP_IDLE};
      STEP_DIV_AVG:  w = '{OP_DIV_AVG,  C_NEVER,       C_NEVER,     STEP_IDLE};
      STEP_WAIT_A:   w = '{OP_NOP,      C_DIV_BUSY,    C_NEVER,     STEP_IDLE};
      STEP_HOLD:     w = '{OP_HOLD,     C_NEVER,       C_NEVER,     STEP_IDLE};
      STEP_FINISH:   w = '{OP_FINISH,   C_OUT_BLOCKED, C_ALWAYS,    STEP_IDLE};
      default:       w = '{OP_NOP,      C_NEVER,       C_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/ecg_r_peak_heart_rate.sv =====
// Top level of the ECG R-peak detector with heart-rate averaging.
// Each accepted sample is smoothed, tested for an R peak at the previous sample, and yields
// one result item. A control program steps a shared multiplier and a serial divider. An item
// without a peak goes from the filter steps to the test step and then to the finish step; a
// peak that forms a rate also passes the mark step, two serial divider passes (one for the rate
// division and one for the average), the range check, the history entry and the hold step.
// No new item is taken while one is in progress. The next item is taken once the result is in
// the output register. While a result waits there, the following item holds on its last step.
// The user must write the configuration registers through the cfg port only while no item is
// in progress; the block itself does not enforce this.
module ecg_r_peak_heart_rate
  import ecgr_pkg::*;
#(
  parameter int AVG_DEPTH   = AVG_DEPTH_DEFAULT,
  parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [SAMPLE_W-1:0]    adc_sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [SAMPLE_W-1:0]    filtered_sample,
  output logic                   peak_flag,
  output logic                   rate_updated,
  output logic [RATE_W-1:0]      heart_rate,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  ctrl_t   ctrl;
  status_t status;

  assign cfg_ready    = 1'b1;
  assign sample_stall = !ctrl.idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha    <= ALPHA_RESET;
      cfg.thresh   <= THRESH_RESET;
      cfg.refr     <= REFR_RESET;
      cfg.numer    <= NUMER_RESET;
      cfg.rate_min <= RATE_MIN_RESET;
      cfg.rate_max <= RATE_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALPHA:    cfg.alpha    <= cfg_data[ALPHA_W-1:0];
        CFG_THRESH:   cfg.thresh   <= cfg_data[THRESH_W-1:0];
        CFG_REFR:     cfg.refr     <= cfg_data[REFR_W-1:0];
        CFG_NUMER:    cfg.numer    <= cfg_data[NUMER_W-1:0];
        CFG_RATE_MIN: cfg.rate_min <= cfg_data[RATE_W-1:0];
        CFG_RATE_MAX: cfg.rate_max <= cfg_data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ecgr_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .ctrl  (ctrl)
  );

  ecgr_datapath #(
    .AVG_DEPTH  (AVG_DEPTH),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .cfg            (cfg),
    .sample_valid   (sample_valid),
    .adc_sample     (adc_sample),
    .result_stall   (result_stall),
    .status         (status),
    .result_valid   (result_valid),
    .filtered_sample(filtered_sample),
    .peak_flag      (peak_flag),
    .rate_updated   (rate_updated),
    .heart_rate     (heart_rate)
  );

endmodule

// ===== src/ecgr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module ecgr_div
  import ecgr_pkg::*;
#(
  parameter int DVD_W = DIV_W,
  parameter int DVS_W = COUNT_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;

  assign shifted = {rem, quotient[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[DVS_W]) begin
        rem      <= trial[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/ecgr_seq.sv =====
// Step counter and control program sequencer.
module ecgr_seq
  import ecgr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            word;
  logic              stay;
  logic              jump;

  function automatic logic cond_eval(input cond_t c, input status_t s);
    logic r;
    unique case (c)
      C_NEVER:       r = 1'b0;
      C_ALWAYS:      r = 1'b1;
      C_NO_INPUT:    r = s.no_input;
      C_NOT_PEAK:    r = s.not_peak;
      C_NO_RATE:     r = s.no_rate;
      C_DIV_BUSY:    r = s.div_busy;
      C_OUT_RANGE:   r = s.out_range;
      C_OUT_BLOCKED: r = s.out_blocked;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    word = ucode_rom(step);
    stay = cond_eval(word.stay, status);
    jump = cond_eval(word.jump, status);
    if (stay) begin
      step_next = step;
    end else if (jump) begin
      step_next = word.target;
    end else begin
      step_next = step + 1'b1;
    end
    ctrl.op   = word.op;
    ctrl.idle = (step == STEP_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== src/ecgr_datapath.sv =====
// Filter, peak test, rate averaging datapath and result register.
module ecgr_datapath
  import ecgr_pkg::*;
#(
  parameter int AVG_DEPTH   = AVG_DEPTH_DEFAULT,
  parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  cfg_t                cfg,
  input  logic                sample_valid,
  input  logic [SAMPLE_W-1:0] adc_sample,
  input  logic                result_stall,
  output status_t             status,
  output logic                result_valid,
  output logic [SAMPLE_W-1:0] filtered_sample,
  output logic                peak_flag,
  output logic                rate_updated,
  output logic [RATE_W-1:0]   heart_rate
);

  localparam int SMOOTH_W = SAMPLE_W + FRAC_BITS;
  localparam int PROD_W   = SMOOTH_W + ALPHA_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int FILL_W   = $clog2(AVG_DEPTH + 1);
  localparam int PTR_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W    = RATE_W + FILL_W;
  localparam logic [SMOOTH_W-1:0] CENTER_FX = SMOOTH_W'(CENTER_INT) << FRAC_BITS;

  logic [SAMPLE_W-1:0]    x;
  logic [ACC_W-1:0]       acc;
  logic [SMOOTH_W-1:0]    smoothed;
  logic [SMOOTH_W-1:0]    prev_value;
  logic [SMOOTH_W-1:0]    prev_prev_value;
  logic [COUNT_WIDTH-1:0] sample_counter;
  logic [COUNT_WIDTH-1:0] last_peak_index;
  logic [COUNT_WIDTH-1:0] gap;
  logic                   peak_seen;
  logic                   peak;
  logic                   updated;
  logic [RATE_W-1:0]      rate_history [AVG_DEPTH];
  logic [PTR_W-1:0]       history_pointer;
  logic [FILL_W-1:0]      history_fill;
  logic [SUM_W-1:0]       history_sum;
  logic [RATE_W-1:0]      held_rate;

  logic [ALPHA_W-1:0]     alpha_c;
  logic [SMOOTH_W-1:0]    mul_a;
  logic [ALPHA_W-1:0]     mul_b;
  logic [PROD_W-1:0]      prod;
  logic [SMOOTH_W-1:0]    thresh_fx;
  logic                   is_peak;
  logic                   div_start;
  logic [DIV_W-1:0]       div_dividend;
  logic [COUNT_WIDTH-1:0] div_divisor;
  logic                   div_busy;
  logic [DIV_W-1:0]       quotient;
  logic                   blocked;

  assign alpha_c   = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign thresh_fx = {cfg.thresh, {FRAC_BITS{1'b0}}};
  assign blocked   = result_valid && result_stall;

  always_comb begin
    if (ctrl.op == OP_MUL_NEW) begin
      mul_a = {x, {FRAC_BITS{1'b0}}};
      mul_b = alpha_c;
    end else begin
      mul_a = smoothed;
      mul_b = ALPHA_ONE - alpha_c;
    end
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign is_peak = (gap > COUNT_WIDTH'(cfg.refr)) && (prev_value > prev_prev_value) &&
                   (prev_value > smoothed) && (prev_value > thresh_fx);

  always_comb begin
    status.no_input    = !sample_valid;
    status.not_peak    = !is_peak;
    status.no_rate     = !peak_seen || (gap == COUNT_WIDTH'(1));
    status.div_busy    = div_busy;
    status.out_range   = (quotient < DIV_W'(cfg.rate_min)) ||
                         (quotient > DIV_W'(cfg.rate_max));
    status.out_blocked = blocked;
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = cfg.numer;
    div_divisor  = gap - 1'b1;
    if (ctrl.op == OP_DIV_RATE) begin
      div_start = 1'b1;
    end else if (ctrl.op == OP_DIV_AVG) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'(history_sum);
      div_divisor  = COUNT_WIDTH'(history_fill);
    end
  end

  ecgr_div #(
    .DVD_W(DIV_W),
    .DVS_W(COUNT_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_IDLE && sample_valid) begin
      x <= adc_sample;
    end
    if (ctrl.op == OP_MUL_OLD) begin
      acc <= ACC_W'(prod);
    end else if (ctrl.op == OP_MUL_NEW) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctrl.op == OP_FILTER) begin
      gap <= sample_counter + 1'b1 - last_peak_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed        <= CENTER_FX;
      prev_value      <= CENTER_FX;
      prev_prev_value <= CENTER_FX;
      sample_counter  <= '0;
      last_peak_index <= '0;
      peak_seen       <= 1'b0;
      peak            <= 1'b0;
      updated         <= 1'b0;
      rate_history    <= '{default: '0};
      history_pointer <= '0;
      history_fill    <= '0;
      history_sum     <= '0;
      held_rate       <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (ctrl.op == OP_FINISH && !blocked) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_FILTER: begin
          smoothed       <= acc[ALPHA_SHIFT +: SMOOTH_W];
          sample_counter <= sample_counter + 1'b1;
          peak           <= 1'b0;
          updated        <= 1'b0;
        end
        OP_TEST: begin
          peak <= is_peak;
        end
        OP_MARK: begin
          last_peak_index <= sample_counter - 1'b1;
          peak_seen       <= 1'b1;
        end
        OP_ENTER: begin
          rate_history[history_pointer] <= quotient[RATE_W-1:0];
          history_sum <= history_sum - SUM_W'(rate_history[history_pointer]) +
                         SUM_W'(quotient[RATE_W-1:0]);
          if (history_pointer == PTR_W'(AVG_DEPTH - 1)) begin
            history_pointer <= '0;
          end else begin
            history_pointer <= history_pointer + 1'b1;
          end
          if (history_fill != FILL_W'(AVG_DEPTH)) begin
            history_fill <= history_fill + 1'b1;
          end
          updated <= 1'b1;
        end
        OP_HOLD: begin
          held_rate <= quotient[RATE_W-1:0];
        end
        OP_FINISH: begin
          if (!blocked) begin
            prev_prev_value <= prev_value;
            prev_value      <= smoothed;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_FINISH && !blocked) begin
      filtered_sample <= smoothed[FRAC_BITS +: SAMPLE_W];
      peak_flag       <= peak;
      rate_updated    <= updated;
      heart_rate      <= held_rate;
    end
  end

endmodule

// ===== test/tb_ecg_r_peak_heart_rate.sv =====
// Self-checking testbench for the ECG R-peak detector with heart-rate averaging.
module tb_ecg_r_peak_heart_rate;
  import ecgr_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int TIMEOUT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int REPORT_CAP      = 100;
  localparam int FRAC            = FRAC_BITS_DEFAULT;
  localparam int FX_W            = SAMPLE_W + FRAC;
  localparam int ACC_W           = FX_W + ALPHA_W + 1;
  localparam int CNT_W           = COUNT_WIDTH_DEFAULT;
  localparam int HIST_N          = AVG_DEPTH_DEFAULT;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                peak;
    logic                updated;
    logic [RATE_W-1:0]   rate;
  } ecg_result_t;

  typedef struct {
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  logic [SAMPLE_W-1:0]    adc_sample = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [SAMPLE_W-1:0]    filtered_sample;
  logic                   peak_flag;
  logic                   rate_updated;
  logic [RATE_W-1:0]      heart_rate;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  ecg_r_peak_heart_rate uut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .adc_sample(adc_sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .filtered_sample(filtered_sample),
    .peak_flag(peak_flag),
    .rate_updated(rate_updated),
    .heart_rate(heart_rate),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfg_t              model_cfg;
  logic [FX_W-1:0]   smoothed;
  logic [FX_W-1:0]   prev_fx;
  logic [FX_W-1:0]   prev_prev_fx;
  logic [CNT_W-1:0]  sample_count;
  logic [CNT_W-1:0]  last_peak;
  logic              peak_seen;
  logic [RATE_W-1:0] rate_hist [HIST_N];
  int                hist_ptr;
  int                hist_fill;
  logic [RATE_W-1:0] held_rate;

  ecg_result_t pending_results [$];
  reg_write_t  writes_pending [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          hold_offs_asked = 0;
  int          hold_offs_done = 0;
  bit          no_idling = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Regression FAIL");
    $finish;
  end

  function automatic ecg_result_t smooth_and_detect(input logic [SAMPLE_W-1:0] x);
    logic [FX_W-1:0]    x_fx;
    logic [ALPHA_W-1:0] a;
    logic [ACC_W-1:0]   acc;
    logic [FX_W-1:0]    filt;
    logic [CNT_W-1:0]   gap;
    logic [CNT_W-1:0]   interval;
    logic [CNT_W-1:0]   bpm;
    int                 sum;
    int                 i;
    ecg_result_t        r;
    x_fx = {x, {FRAC{1'b0}}};
    a = (model_cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : model_cfg.alpha;
    acc = (ACC_W'(smoothed) * ACC_W'(ALPHA_ONE - a) + ACC_W'(x_fx) * ACC_W'(a)) >> ALPHA_SHIFT;
    filt = acc[FX_W-1:0];
    smoothed = filt;
    sample_count = sample_count + 1'b1;
    gap = sample_count - last_peak;
    r = '0;
    if (gap > CNT_W'(model_cfg.refr) && prev_fx > prev_prev_fx && prev_fx > filt &&
        prev_fx > {model_cfg.thresh, {FRAC{1'b0}}}) begin
      r.peak = 1'b1;
      if (peak_seen) begin
        interval = gap - 1'b1;
        if (interval != '0) begin
          bpm = CNT_W'(model_cfg.numer) / interval;
          if (bpm >= CNT_W'(model_cfg.rate_min) && bpm <= CNT_W'(model_cfg.rate_max)) begin
            rate_hist[hist_ptr] = bpm[RATE_W-1:0];
            hist_ptr = (hist_ptr + 1) % HIST_N;
            if (hist_fill < HIST_N) hist_fill++;
            sum = 0;
            for (i = 0; i < hist_fill; i++) sum += rate_hist[i];
            held_rate = RATE_W'(sum / hist_fill);
            r.updated = 1'b1;
          end
        end
      end
      last_peak = sample_count - 1'b1;
      peak_seen = 1'b1;
    end
    prev_prev_fx = prev_fx;
    prev_fx = filt;
    r.filtered = filt[FX_W-1:FRAC];
    r.rate = held_rate;
    return r;
  endfunction

  function automatic void model_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_ALPHA:    model_cfg.alpha = d[ALPHA_W-1:0];
      CFG_THRESH:   model_cfg.thresh = d[THRESH_W-1:0];
      CFG_REFR:     model_cfg.refr = d[REFR_W-1:0];
      CFG_NUMER:    model_cfg.numer = d[NUMER_W-1:0];
      CFG_RATE_MIN: model_cfg.rate_min = d[RATE_W-1:0];
      CFG_RATE_MAX: model_cfg.rate_max = d[RATE_W-1:0];
      default: ;
    endcase
  endfunction

  // Bits above the register width carry random junk that the block must drop.
  function automatic void stage_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input int unsigned value);
    reg_write_t w;
    w.idx = idx;
    w.data = CFG_DATA_W'($urandom);
    case (idx)
      CFG_ALPHA:    w.data[ALPHA_W-1:0] = value[ALPHA_W-1:0];
      CFG_THRESH:   w.data[THRESH_W-1:0] = value[THRESH_W-1:0];
      CFG_REFR:     w.data = value[REFR_W-1:0];
      CFG_NUMER:    w.data = value[NUMER_W-1:0];
      CFG_RATE_MIN: w.data[RATE_W-1:0] = value[RATE_W-1:0];
      CFG_RATE_MAX: w.data[RATE_W-1:0] = value[RATE_W-1:0];
      default:      w.data = value[CFG_DATA_W-1:0];
    endcase
    writes_pending.push_back(w);
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned roll;
    if (no_idling) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip_sample(input int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return SAMPLE_W'(v);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned idle;
    idle = pick_idle();
    if (idle != 0) begin
      sample_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    sample_valid <= 1'b1;
    adc_sample <= value;
    do @(posedge clk); while (sample_stall);
    pending_results.push_back(smooth_and_detect(value));
  endtask

  task automatic wait_for_results();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apply_writes();
    reg_write_t w;
    wait_for_results();
    while (writes_pending.size() != 0) begin
      w = writes_pending.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      do @(posedge clk); while (!cfg_ready);
      model_write(w.idx, w.data);
    end
    cfg_valid <= 1'b0;
  endtask

  // One beat is a noisy baseline with a short rising spike; about one beat in ten is
  // replaced by pure noise.
  task automatic send_beats(input int unsigned count, input int unsigned period,
                            input int unsigned base);
    int unsigned b;
    int unsigned s;
    int unsigned len;
    int unsigned span;
    int unsigned start;
    int unsigned amp;
    for (b = 0; b < count; b++) begin
      len = period - period / 8 + $urandom_range(0, period / 4);
      span = $urandom_range(1, 3);
      amp = $urandom_range(1200, 2047);
      start = $urandom_range(0, len - span);
      if ($urandom_range(0, 9) == 0) begin
        for (s = 0; s < len; s++) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
      end else begin
        for (s = 0; s < len; s++) begin
          if (s >= start && s < start + span)
            send_sample(clip_sample(base + amp * (s - start + 1) / span));
          else
            send_sample(clip_sample(int'(base) + int'($urandom_range(0, 160)) - 80));
        end
      end
    end
  endtask

  task automatic test_field_extremes();
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'd0);
  endtask

  task automatic test_peak_and_rate();
    stage_write(CFG_ALPHA, 1024);
    stage_write(CFG_THRESH, 2000);
    stage_write(CFG_REFR, 0);
    stage_write(CFG_NUMER, 100);
    stage_write(CFG_RATE_MIN, 30);
    stage_write(CFG_RATE_MAX, 220);
    stage_write(CFG_SPARE_LOW, $urandom);
    stage_write(CFG_SPARE_HIGH, $urandom);
    apply_writes();
    send_sample(12'd1000);
    send_sample(12'd3000);
    send_sample(12'd1000);
    send_sample(12'd3000);
    send_sample(12'd1000);
    send_sample(12'd3000);
    send_sample(12'd3000);
    send_sample(12'd1000);
    send_sample(12'd2000);
    send_sample(12'd1000);
  endtask

  task automatic test_rate_edges();
    stage_write(CFG_ALPHA, 2047);
    stage_write(CFG_REFR, 2);
    stage_write(CFG_NUMER, 1000);
    stage_write(CFG_RATE_MIN, 200);
    stage_write(CFG_RATE_MAX, 100);
    apply_writes();
    send_sample(12'd3000);
    send_sample(12'd1000);
    send_sample(12'd3000);
    send_sample(12'd1000);
    stage_write(CFG_NUMER, 0);
    stage_write(CFG_RATE_MIN, 0);
    stage_write(CFG_RATE_MAX, 255);
    apply_writes();
    send_sample(12'd3000);
    send_sample(12'd1000);
    send_sample(12'd3000);
    send_sample(12'd1000);
    stage_write(CFG_REFR, 5);
    apply_writes();
    send_sample(12'd3000);
    send_sample(12'd1000);
  endtask

  task automatic test_setting_extremes();
    int k;
    stage_write(CFG_ALPHA, 0);
    stage_write(CFG_THRESH, 0);
    stage_write(CFG_REFR, 0);
    stage_write(CFG_NUMER, 1);
    stage_write(CFG_RATE_MIN, 0);
    stage_write(CFG_RATE_MAX, 0);
    apply_writes();
    for (k = 0; k < 8; k++) send_sample(SAMPLE_W'($urandom));
    stage_write(CFG_ALPHA, 1024);
    apply_writes();
    for (k = 0; k < 40; k++) send_sample(SAMPLE_W'($urandom));
    stage_write(CFG_THRESH, 4095);
    stage_write(CFG_REFR, 65535);
    stage_write(CFG_NUMER, 65535);
    stage_write(CFG_RATE_MIN, 255);
    stage_write(CFG_RATE_MAX, 255);
    apply_writes();
    for (k = 0; k < 12; k++) send_sample(SAMPLE_W'($urandom));
  endtask

  task automatic test_random_beats();
    int unsigned phase;
    int unsigned period;
    int unsigned base;
    int unsigned bpm;
    for (phase = 0; phase < 7; phase++) begin
      period = $urandom_range(8, 40);
      base = $urandom_range(1700, 2200);
      bpm = $urandom_range(40, 200);
      if ($urandom_range(0, 7) == 0) stage_write(CFG_ALPHA, $urandom_range(1025, 2047));
      else stage_write(CFG_ALPHA, $urandom_range(250, 1024));
      stage_write(CFG_THRESH, $urandom_range(2150, 2600));
      stage_write(CFG_REFR, $urandom_range(0, period / 2));
      stage_write(CFG_NUMER, period * bpm);
      if ($urandom_range(0, 7) == 0) begin
        stage_write(CFG_RATE_MIN, 200);
        stage_write(CFG_RATE_MAX, 100);
      end else begin
        stage_write(CFG_RATE_MIN, $urandom_range(0, 60));
        stage_write(CFG_RATE_MAX, $urandom_range(150, 255));
      end
      apply_writes();
      no_idling = (phase % 3 == 2);
      send_beats(250 / period + 1, period, base);
    end
    no_idling = 1'b0;
  endtask

  // The receiver holds off while items keep coming, so the block must stall its input.
  task automatic test_output_hold_off();
    no_idling = 1'b1;
    hold_offs_asked++;
    send_beats(2, 12, 2000);
    no_idling = 1'b0;
  endtask

  initial begin : result_side
    int unsigned n;
    forever begin
      if (hold_offs_done != hold_offs_asked) begin
        hold_offs_done++;
        result_stall <= 1'b1;
        for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
      end else begin
        result_stall <= (!no_idling && $urandom_range(0, 2) == 0);
        repeat (pick_idle() + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    ecg_result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("item with nothing pending, filtered_sample", filtered_sample, 0);
      end else begin
        want = pending_results.pop_front();
        if (filtered_sample !== want.filtered)
          report_mismatch("filtered_sample", filtered_sample, want.filtered);
        if (peak_flag !== want.peak)
          report_mismatch("peak_flag", peak_flag, want.peak);
        if (rate_updated !== want.updated)
          report_mismatch("rate_updated", rate_updated, want.updated);
        if (heart_rate !== want.rate)
          report_mismatch("heart_rate", heart_rate, want.rate);
      end
    end
  end

  initial begin
    model_cfg = '{ALPHA_RESET, THRESH_RESET, REFR_RESET, NUMER_RESET,
                  RATE_MIN_RESET, RATE_MAX_RESET};
    smoothed = FX_W'(CENTER_INT) << FRAC;
    prev_fx = smoothed;
    prev_prev_fx = smoothed;
    sample_count = '0;
    last_peak = '0;
    peak_seen = 1'b0;
    foreach (rate_hist[i]) rate_hist[i] = '0;
    hist_ptr = 0;
    hist_fill = 0;
    held_rate = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_peak_and_rate();
    test_rate_edges();
    test_setting_extremes();
    test_random_beats();
    test_output_hold_off();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
